// ----- hdl/swmm_pkg.sv -----
// shared constants and types for the sliding window min/max core
`default_nettype none

package swmm_pkg;

  // field widths
  localparam int VAL_W  = 32;
  localparam int WLEN_W = 7;
  localparam int PTS_W  = 7;

  // packed channel widths
  localparam int IN_TDATA_W  = 3 * VAL_W;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * VAL_W - PTS_W;

  // defaults
  localparam int WINDOW_MAX_DEF = 64;
  localparam int WINDOW_LEN_RST = 30;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  // one stored point
  typedef struct packed {
    logic             vld;
    logic [VAL_W-1:0] cnt;
    logic [VAL_W-1:0] bkg;
  } entry_t;

endpackage

`default_nettype wire

// ----- hdl/sliding_window_min_max_core.sv -----
// sliding window min/max tracker with rescan on eviction
`default_nettype none

// channel  | ports                  | item contents
// ---------+------------------------+-----------------------------------------------
// input    | in_tvalid/tready/tdata | tdata: timestamp, count_value, background_value
//          | in_tuser               | tuser: opcode (add point / clear window)
// result   | out_tvalid/tready/tdata| tdata: max_value, min_value, stored_points
// config   | cfg_wr_en/cfg_wr_data  | window_length, taken only while window empty
//
// one item at a time: an add or clear without eviction passes through the execute and
// done steps, with the result registered from the done step; an eviction adds a step for the
// memory read of the oldest slot; each rescan walks the window through the single
// memory read port, with a pass for the maximum, the minimum or both
// synchronous active-low reset empties the window and zeroes both extremes
// a result that is not taken still lets the next item in, which then waits in its
// last step until the output register is free

module sliding_window_min_max_core #(
  parameter int WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  // [31:0] timestamp, [63:32] count_value, [95:64] background_value
  input  wire logic [swmm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] opcode
  input  wire logic [swmm_pkg::IN_TUSER_W-1:0]  in_tuser,
  // result channel
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  // [31:0] max_value, [63:32] min_value, [70:64] stored_points, [71] zero
  output      logic [swmm_pkg::OUT_TDATA_W-1:0] out_tdata,
  // configuration
  input  wire logic                             cfg_wr_en,
  input  wire logic [swmm_pkg::WLEN_W-1:0]      cfg_wr_data
);

  import swmm_pkg::*;

  localparam int IDXW   = $clog2(WINDOW_MAX);
  localparam int FILLW  = $clog2(WINDOW_MAX + 1);
  // reset window length, saturated to the store depth
  localparam int WL_RST = (WINDOW_LEN_RST > WINDOW_MAX) ? WINDOW_MAX : WINDOW_LEN_RST;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN_MAX,
    S_SCAN_MIN,
    S_DONE
  } state_t;

  // control state
  state_t                 state_r, state_nxt;
  logic [FILLW-1:0]       fill_r, fill_nxt;
  logic [IDXW-1:0]        oldest_r, oldest_nxt;
  logic [FILLW-1:0]       wl_r, wl_nxt;
  logic [VAL_W-1:0]       max_r, max_nxt;
  logic [VAL_W-1:0]       min_r, min_nxt;
  logic                   need_min_r, need_min_nxt;
  logic [FILLW-1:0]       scan_cnt_r, scan_cnt_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;

  // payload
  logic [VAL_W-1:0]       acc_r, acc_nxt;
  opcode_t                op_r, op_nxt;
  logic                   ts_zero_r, ts_zero_nxt;
  logic [VAL_W-1:0]       cv_r, cv_nxt;
  logic [VAL_W-1:0]       bg_r, bg_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // point store, one write and one registered read per cycle
  entry_t                 mem [WINDOW_MAX];
  entry_t                 rd_data_r;
  logic                   mem_we;
  logic [IDXW-1:0]        mem_wa;
  entry_t                 mem_wd;
  logic                   mem_re;
  logic [IDXW-1:0]        mem_ra;

  // datapath helpers
  logic [FILLW-1:0]       wl_cfg;
  logic [VAL_W-1:0]       new_hi, new_lo;
  logic [VAL_W-1:0]       base_max, base_min;
  logic [FILLW:0]         slot_sum;
  logic [IDXW-1:0]        app_slot;
  logic [FILLW-1:0]       oldest_inc;
  logic [VAL_W-1:0]       ent_hi, ent_lo;
  logic [VAL_W-1:0]       acc_upd;
  logic                   scan_last;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // window length write: zero counts as one, saturate at store depth
  always_comb begin
    if (cfg_wr_data == '0) begin
      wl_cfg = FILLW'(1);
    end else if (int'(cfg_wr_data) > WINDOW_MAX) begin
      wl_cfg = FILLW'(WINDOW_MAX);
    end else begin
      wl_cfg = FILLW'(cfg_wr_data);
    end
  end

  // larger and smaller value of the pending point
  assign new_hi = (cv_r > bg_r) ? cv_r : bg_r;
  assign new_lo = (cv_r < bg_r) ? cv_r : bg_r;

  // the first stored point seeds both extremes
  assign base_max = (fill_r == '0) ? new_hi : max_r;
  assign base_min = (fill_r == '0) ? new_lo : min_r;

  // append slot while filling, wrapped once at the window length
  assign slot_sum = (FILLW+1)'(oldest_r) + (FILLW+1)'(fill_r);
  always_comb begin
    if (slot_sum >= (FILLW+1)'(wl_r)) begin
      app_slot = IDXW'(slot_sum - (FILLW+1)'(wl_r));
    end else begin
      app_slot = IDXW'(slot_sum);
    end
  end

  assign oldest_inc = FILLW'(oldest_r) + FILLW'(1);

  // shared compare unit for the rescan: one stored point per cycle
  assign ent_hi    = (rd_data_r.cnt > rd_data_r.bkg) ? rd_data_r.cnt : rd_data_r.bkg;
  assign ent_lo    = (rd_data_r.cnt < rd_data_r.bkg) ? rd_data_r.cnt : rd_data_r.bkg;
  assign scan_last = rd_vld_r && (scan_cnt_r == fill_r);

  always_comb begin
    acc_upd = acc_r;
    if (rd_vld_r && rd_data_r.vld) begin
      if (state_r == S_SCAN_MAX) begin
        if (ent_hi > acc_r) begin
          acc_upd = ent_hi;
        end
      end else begin
        if (ent_lo < acc_r) begin
          acc_upd = ent_lo;
        end
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    oldest_nxt     = oldest_r;
    wl_nxt         = wl_r;
    max_nxt        = max_r;
    min_nxt        = min_r;
    need_min_nxt   = need_min_r;
    scan_cnt_nxt   = scan_cnt_r;
    rd_vld_nxt     = 1'b0;
    out_tvalid_nxt = out_tvalid_r;
    acc_nxt        = acc_r;
    op_nxt         = op_r;
    ts_zero_nxt    = ts_zero_r;
    cv_nxt         = cv_r;
    bg_nxt         = bg_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_wa         = oldest_r;
    mem_wd         = '{vld: !ts_zero_r, cnt: cv_r, bkg: bg_r};
    mem_re         = 1'b0;
    mem_ra         = oldest_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    // length only changes on an empty window
    if (cfg_wr_en && (fill_r == '0)) begin
      wl_nxt     = wl_cfg;
      oldest_nxt = '0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt      = opcode_t'(in_tuser[0]);
          ts_zero_nxt = (in_tdata[VAL_W-1:0] == '0);
          cv_nxt      = in_tdata[2*VAL_W-1:VAL_W];
          bg_nxt      = in_tdata[3*VAL_W-1:2*VAL_W];
          state_nxt   = S_EXEC;
        end
      end

      S_EXEC: begin
        if (op_r == OP_CLEAR) begin
          fill_nxt   = '0;
          oldest_nxt = '0;
          max_nxt    = '0;
          min_nxt    = '0;
          state_nxt  = S_DONE;
        end else if (ts_zero_r && (fill_r == '0)) begin
          // error point into an empty window is dropped
          state_nxt = S_DONE;
        end else begin
          max_nxt = base_max;
          min_nxt = base_min;
          if (!ts_zero_r) begin
            max_nxt = (new_hi > base_max) ? new_hi : base_max;
            min_nxt = (new_lo < base_min) ? new_lo : base_min;
          end
          if (fill_r < wl_r) begin
            mem_we    = 1'b1;
            mem_wa    = app_slot;
            fill_nxt  = fill_r + FILLW'(1);
            state_nxt = S_DONE;
          end else begin
            // full: fetch the oldest point before overwriting it
            mem_re    = 1'b1;
            mem_ra    = oldest_r;
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        mem_we = 1'b1;
        mem_wa = oldest_r;
        if (oldest_inc >= wl_r) begin
          oldest_nxt = '0;
        end else begin
          oldest_nxt = IDXW'(oldest_inc);
        end
        scan_cnt_nxt = '0;
        need_min_nxt = rd_data_r.vld &&
                       ((rd_data_r.bkg <= min_r) || (rd_data_r.cnt <= min_r));
        if (rd_data_r.vld && ((rd_data_r.cnt >= max_r) || (rd_data_r.bkg >= max_r))) begin
          acc_nxt   = '0;
          state_nxt = S_SCAN_MAX;
        end else if (need_min_nxt) begin
          acc_nxt   = max_r;
          state_nxt = S_SCAN_MIN;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_SCAN_MAX, S_SCAN_MIN: begin
        if (scan_cnt_r < fill_r) begin
          mem_re       = 1'b1;
          mem_ra       = scan_cnt_r[IDXW-1:0];
          scan_cnt_nxt = scan_cnt_r + FILLW'(1);
          rd_vld_nxt   = 1'b1;
        end
        acc_nxt = acc_upd;
        if (scan_last) begin
          if (state_r == S_SCAN_MAX) begin
            max_nxt = acc_upd;
            if (need_min_r) begin
              // minimum starts from the fresh maximum
              scan_cnt_nxt = '0;
              state_nxt    = S_SCAN_MIN;
            end else begin
              state_nxt = S_DONE;
            end
          end else begin
            min_nxt   = acc_upd;
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = {{OUT_PAD_W{1'b0}}, PTS_W'(fill_r), min_r, max_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    op_r       <= op_nxt;
    ts_zero_r  <= ts_zero_nxt;
    cv_r       <= cv_nxt;
    bg_r       <= bg_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      oldest_r     <= '0;
      wl_r         <= FILLW'(WL_RST);
      max_r        <= '0;
      min_r        <= '0;
      need_min_r   <= 1'b0;
      scan_cnt_r   <= '0;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      oldest_r     <= oldest_nxt;
      wl_r         <= wl_nxt;
      max_r        <= max_nxt;
      min_r        <= min_nxt;
      need_min_r   <= need_min_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // point store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // fill never runs past the window length
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= wl_r)
    else $error("fill level above window length");

  // the oldest pointer only moves once the window is full
  a_oldest_full: assert property (@(posedge clk) disable iff (!rst_n)
    (oldest_r != '0) |-> (fill_r == wl_r))
    else $error("oldest pointer moved on a partly filled window");

  // a rescan only runs over a full window and never writes the store
  a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN_MAX) || (state_r == S_SCAN_MIN)) |-> ((fill_r == wl_r) && !mem_we))
    else $error("rescan on a window that is not full");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item taken while one is in progress");

endmodule

`default_nettype wire
